// ===== sv/insertion_sorter_assert.svh =====
// assertion macros shared by the checker
`ifndef INSERTION_SORTER_ASSERT_SVH
`define INSERTION_SORTER_ASSERT_SVH

// same-cycle implication, sampled on the rising clock, off during reset
`define ISRT_ASSERT_NOW(name, ante, cons, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, sampled on the rising clock, off during reset
`define ISRT_ASSERT_NEXT(name, ante, cons, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== sv/isrt_pkg.sv =====
package isrt_pkg;

   localparam int CAPACITY = 32;
   localparam int DATA_W   = 32;

   // what a cell shows to its neighbors
   typedef struct packed {
      logic [DATA_W-1:0] value;
      logic              valid;
      logic              gt;
   } cell_link_type;

   // broadcast from the top level to every cell
   typedef struct packed {
      logic              ins;
      logic              drain;
      logic [DATA_W-1:0] value;
   } cell_ctrl_type;

endpackage

// ===== sv/isrt_cell.sv =====
module isrt_cell (
   input  logic                   clock,
   input  logic                   reset,
   input  isrt_pkg::cell_ctrl_type ctrl,
   input  isrt_pkg::cell_link_type left_link,
   input  isrt_pkg::cell_link_type right_link,
   output isrt_pkg::cell_link_type own_link
);
   import isrt_pkg::*;

   logic [DATA_W-1:0] value_ff;
   logic [DATA_W-1:0] value_in;
   logic              valid_ff;
   logic              valid_in;
   logic              gt;

   // an empty cell counts as greater, so the insert point is the first such cell
   assign gt = !valid_ff || ($signed(value_ff) > $signed(ctrl.value));

   always_comb begin
      value_in = value_ff;
      valid_in = valid_ff;
      priority if (ctrl.drain) begin
         value_in = right_link.value;
         valid_in = right_link.valid;
      end else if (ctrl.ins && gt) begin
         if (left_link.gt) begin
            // shift up by one to make room below
            value_in = left_link.value;
            valid_in = left_link.valid;
         end else begin
            value_in = ctrl.value;
            valid_in = 1'b1;
         end
      end else begin
         value_in = value_ff;
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign own_link.value = value_ff;
   assign own_link.valid = valid_ff;
   assign own_link.gt    = gt;

endmodule

// ===== sv/insertion_sorter.sv =====
// channel   direction  handshake          payload
// req       in         start & !busy      req_value, req_end_of_set
// rsp       out        rsp_valid strobe   rsp_sorted_value, rsp_final_res, rsp_overflowed
//
// an item without end of set is stored as it is taken: all cells compare in parallel
// and shift on the same edge, so start may stay high back to back
// an item with end of set is inserted, then busy rises and the chain shifts down
// one cell a cycle, one result a cycle from cell 0, until the last stored value is out
// reset empties every cell and clears the drop flag at once
// the receiver cannot stall: each result shows for exactly one cycle
module insertion_sorter (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic signed [isrt_pkg::DATA_W-1:0] req_value,
   input  logic                          req_end_of_set,
   output logic                          rsp_valid,
   output logic signed [isrt_pkg::DATA_W-1:0] rsp_sorted_value,
   output logic                          rsp_final_res,
   output logic                          rsp_overflowed
);
   import isrt_pkg::*;

   localparam logic ST_IDLE  = 1'b0;
   localparam logic ST_DRAIN = 1'b1;

   logic          state_ff;
   logic          state_in;
   logic          drop_ff;
   logic          drop_in;
   logic          accept;
   logic          full;
   cell_ctrl_type ctrl;
   cell_link_type link [CAPACITY];
   cell_link_type edge_link;

   assign accept    = start && (state_ff == ST_IDLE);
   assign full      = link[CAPACITY-1].valid;
   assign edge_link = '0;

   assign ctrl.ins   = accept && !full;
   assign ctrl.drain = (state_ff == ST_DRAIN);
   assign ctrl.value = req_value;

   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      cell_link_type left_link;
      cell_link_type right_link;
      if (i == 0) begin : g_first
         assign left_link = edge_link;
      end else begin : g_mid_l
         assign left_link = link[i-1];
      end
      if (i == CAPACITY - 1) begin : g_last
         assign right_link = edge_link;
      end else begin : g_mid_r
         assign right_link = link[i+1];
      end
      isrt_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .ctrl       (ctrl),
         .left_link  (left_link),
         .right_link (right_link),
         .own_link   (link[i])
      );
   end

   assign rsp_valid        = (state_ff == ST_DRAIN) && link[0].valid;
   assign rsp_sorted_value = $signed(link[0].value);
   assign rsp_final_res    = !link[1].valid;
   assign rsp_overflowed   = drop_ff;
   assign busy             = (state_ff == ST_DRAIN);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept && req_end_of_set) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (!(link[0].valid && link[1].valid)) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      drop_in = drop_ff;
      priority if (accept && full) begin
         drop_in = 1'b1;
      end else if (rsp_valid && rsp_final_res) begin
         drop_in = 1'b0;
      end else begin
         drop_in = drop_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         drop_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         drop_ff  <= drop_in;
      end
   end

endmodule

// ===== sv/isrt_checker.sv =====
`include "insertion_sorter_assert.svh"

module isrt_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          start,
   input logic                          busy,
   input logic                          req_end_of_set,
   input logic                          rsp_valid,
   input logic                          rsp_final_res,
   input logic                          rsp_overflowed
);
   import isrt_pkg::*;

   `ISRT_ASSERT_NOW(a_rsp_only_busy, rsp_valid, busy, "result beat outside an output run")
   `ISRT_ASSERT_NEXT(a_eos_starts_run, start && !busy && req_end_of_set, busy && rsp_valid, "end of set did not start an output run")
   `ISRT_ASSERT_NEXT(a_final_ends_run, rsp_valid && rsp_final_res, !rsp_valid && !busy, "output run continued after final beat")
   `ISRT_ASSERT_NEXT(a_run_no_gap, rsp_valid && !rsp_final_res, rsp_valid, "gap inside an output run")
   `ISRT_ASSERT_NEXT(a_ovf_steady, rsp_valid && !rsp_final_res, rsp_overflowed == $past(rsp_overflowed), "overflow flag changed inside a run")

endmodule

bind insertion_sorter isrt_checker u_isrt_checker (
   .clock          (clock),
   .reset          (reset),
   .start          (start),
   .busy           (busy),
   .req_end_of_set (req_end_of_set),
   .rsp_valid      (rsp_valid),
   .rsp_final_res  (rsp_final_res),
   .rsp_overflowed (rsp_overflowed)
);
